>>> hdl/rplm_pkg.sv
package rplm_pkg;

    // Event codes carried on the op field.
    localparam logic [1:0] OP_PACKET = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Register indexes on the configuration port.
    localparam logic REG_COUNTING = 1'b0;
    localparam logic REG_MASK     = 1'b1;

    localparam int          HOP_COUNT_DEF  = 8;
    localparam logic [7:0]  MASK_RESET     = 8'd128;
    localparam logic [11:0] BASE_MHZ       = 12'd2400;
    localparam logic [9:0]  PER_MILLE      = 10'd1000;
    localparam logic [6:0]  RSSI_MAX       = 7'd127;

    // Shared divider geometry: a 32-bit count times 1000 needs 42 bits, and
    // the sum of two 32-bit counts needs 33.
    localparam int DIVIDEND_W = 42;
    localparam int DIVISOR_W  = 33;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_AVG,
        ST_PM,
        ST_COMMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic prep;
        logic div_start;
        logic div_sel_pm;
        logic take_avg;
        logic take_pm;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic report;
        logic div_done;
        logic out_free;
    } t_sts;

    // Frequency offsets of the hop sequence, in MHz above the band base.
    function automatic logic [11:0] chan_offset(input logic [2:0] idx);
        logic [11:0] off;
        case (idx)
            3'd0:    off = 12'd2;
            3'd1:    off = 12'd14;
            3'd2:    off = 12'd36;
            3'd3:    off = 12'd56;
            3'd4:    off = 12'd66;
            3'd5:    off = 12'd78;
            3'd6:    off = 12'd0;
            3'd7:    off = 12'd22;
            default: off = 12'd0;
        endcase
        return off;
    endfunction

endpackage

>>> hdl/rplm_div.sv
module rplm_div
    import rplm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    // Restoring radix-2 divider, one quotient bit per cycle. The dividend
    // shifts out of the top of r_quo while quotient bits shift in below.
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIVISOR_W:0] trial;
    logic [DIVISOR_W:0] diff;

    always_comb begin
        trial = {r_rem, r_quo[DIVIDEND_W-1]};
        diff  = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIVIDEND_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!diff[DIVISOR_W]) begin
                r_rem <= diff[DIVISOR_W-1:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[DIVISOR_W-1:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> hdl/rplm_ctrl.sv
module rplm_ctrl
    import rplm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_PREP;
            end
            ST_PREP: begin
                n_state = i_sts.report ? ST_AVG : ST_COMMIT;
            end
            ST_AVG: begin
                if (i_sts.div_done) n_state = ST_PM;
            end
            ST_PM: begin
                if (i_sts.div_done) n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            ST_PREP: begin
                o_cmd.prep      = 1'b1;
                o_cmd.div_start = i_sts.report;
            end
            ST_AVG: begin
                o_cmd.take_avg   = i_sts.div_done;
                o_cmd.div_start  = i_sts.div_done;
                o_cmd.div_sel_pm = 1'b1;
            end
            ST_PM: begin
                o_cmd.div_sel_pm = 1'b1;
                o_cmd.take_pm    = i_sts.div_done;
            end
            ST_COMMIT: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> hdl/rplm_dp.sv
module rplm_dp
    import rplm_pkg::*;
#(
    parameter int HOP_COUNT = HOP_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_counting_en,
    input  logic [7:0]         i_ctrl_mask,
    input  logic [1:0]         i_op,
    input  logic               i_crc_good,
    input  logic [6:0]         i_rssi_sample,
    input  logic [7:0]         i_packet_type,
    input  logic [31:0]        i_sequence_number,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic               o_control_seen,
    output logic [7:0]         o_control_type,
    output logic [11:0]        o_channel_mhz,
    output logic [31:0]        o_total_count,
    output logic [31:0]        o_lost_count,
    output logic [31:0]        o_duplicate_count,
    output logic [31:0]        o_packets_per_interval,
    output logic signed [7:0]  o_average_rssi_dbm,
    output logic [9:0]         o_loss_per_mille
);

    localparam int HOP_W = (HOP_COUNT > 1) ? $clog2(HOP_COUNT) : 1;

    // Captured input beat.
    logic [1:0]  r_op;
    logic        r_crc;
    logic [6:0]  r_rssi;
    logic [7:0]  r_ptype;
    logic [31:0] r_seq;

    // Link statistics.
    logic [31:0]      r_total, n_total;
    logic [31:0]      r_lost, n_lost;
    logic [31:0]      r_dup, n_dup;
    logic [31:0]      r_last_seq, n_last_seq;
    logic             r_seq_valid, n_seq_valid;
    logic [31:0]      r_rssi_sum, n_rssi_sum;
    logic [31:0]      r_rssi_cnt, n_rssi_cnt;
    logic [31:0]      r_tal, n_tal;
    logic [HOP_W-1:0] r_hop, n_hop;

    // Report operands and results.
    logic [DIVIDEND_W-1:0] r_prod;
    logic [DIVISOR_W-1:0]  r_denom;
    logic [7:0]            r_avg;
    logic [9:0]            r_pm;

    // Output register.
    logic        r_out_valid;
    logic        r_o_ctrl_seen;
    logic [7:0]  r_o_ctrl_type;
    logic [11:0] r_o_chan;
    logic [31:0] r_o_total;
    logic [31:0] r_o_lost;
    logic [31:0] r_o_dup;
    logic [31:0] r_o_pps;
    logic [7:0]  r_o_avg;
    logic [9:0]  r_o_pm;

    logic                  div_busy;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_q;
    logic [DIVIDEND_W-1:0] div_a;
    logic [DIVISOR_W-1:0]  div_b;

    logic       report;
    logic       pkt_ok;
    logic       is_ctrl;
    logic       is_data;
    logic [5:0] hop_ext;
    logic [6:0] avg_sat;

    assign report  = (r_op == OP_TICK) && i_counting_en;
    assign pkt_ok  = (r_op == OP_PACKET) && r_crc;
    assign is_ctrl = |(r_ptype & i_ctrl_mask);
    assign is_data = pkt_ok && !is_ctrl && i_counting_en;

    assign o_sts.report   = report;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_crc   <= i_crc_good;
            r_rssi  <= i_rssi_sample;
            r_ptype <= i_packet_type;
            r_seq   <= i_sequence_number;
        end
    end

    // Operands for the loss ratio; the product gets a register of its own.
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_prod  <= DIVIDEND_W'(r_lost) * DIVIDEND_W'(PER_MILLE);
            r_denom <= {1'b0, r_lost} + {1'b0, r_total};
        end
    end

    assign div_a = i_cmd.div_sel_pm ? r_prod  : DIVIDEND_W'(r_rssi_sum);
    assign div_b = i_cmd.div_sel_pm ? r_denom : DIVISOR_W'(r_rssi_cnt);

    rplm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign avg_sat = (|div_q[DIVIDEND_W-1:7]) ? RSSI_MAX : div_q[6:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_avg) begin
            r_avg <= (r_rssi_cnt == 32'd0) ? 8'd0 : 8'(8'd0 - {1'b0, avg_sat});
        end
        if (i_cmd.take_pm) begin
            r_pm <= (r_denom == '0) ? 10'd0 : div_q[9:0];
        end
    end

    always_comb begin
        n_total     = r_total;
        n_lost      = r_lost;
        n_dup       = r_dup;
        n_last_seq  = r_last_seq;
        n_seq_valid = r_seq_valid;
        n_rssi_sum  = r_rssi_sum;
        n_rssi_cnt  = r_rssi_cnt;
        n_tal       = r_tal;
        n_hop       = r_hop;
        if (pkt_ok) begin
            n_rssi_sum = r_rssi_sum + 32'(r_rssi);
            n_rssi_cnt = r_rssi_cnt + 32'd1;
            n_hop      = (r_hop == HOP_W'(HOP_COUNT - 1)) ? '0 : r_hop + 1'b1;
            if (is_data) begin
                n_total = r_total + 32'd1;
                if (!r_seq_valid) begin
                    n_seq_valid = 1'b1;
                    n_last_seq  = r_seq;
                end else if (r_seq == r_last_seq) begin
                    n_dup = r_dup + 32'd1;
                end else begin
                    n_lost     = r_lost + (r_seq - r_last_seq - 32'd1);
                    n_last_seq = r_seq;
                end
            end
        end else if (report) begin
            n_tal      = r_total;
            n_rssi_sum = '0;
            n_rssi_cnt = '0;
        end else if (r_op == OP_CLEAR) begin
            n_total     = '0;
            n_lost      = '0;
            n_dup       = '0;
            n_tal       = '0;
            n_seq_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_lost      <= '0;
            r_dup       <= '0;
            r_last_seq  <= '0;
            r_seq_valid <= 1'b0;
            r_rssi_sum  <= '0;
            r_rssi_cnt  <= '0;
            r_tal       <= '0;
            r_hop       <= '0;
        end else if (i_cmd.commit) begin
            r_total     <= n_total;
            r_lost      <= n_lost;
            r_dup       <= n_dup;
            r_last_seq  <= n_last_seq;
            r_seq_valid <= n_seq_valid;
            r_rssi_sum  <= n_rssi_sum;
            r_rssi_cnt  <= n_rssi_cnt;
            r_tal       <= n_tal;
            r_hop       <= n_hop;
        end
    end

    assign hop_ext = 6'(n_hop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_ctrl_seen <= pkt_ok && is_ctrl;
            r_o_ctrl_type <= (pkt_ok && is_ctrl) ? r_ptype : 8'd0;
            r_o_chan      <= BASE_MHZ + chan_offset(hop_ext[2:0]);
            r_o_total     <= n_total;
            r_o_lost      <= n_lost;
            r_o_dup       <= n_dup;
            r_o_pps       <= report ? (r_total - r_tal) : 32'd0;
            r_o_avg       <= report ? r_avg : 8'd0;
            r_o_pm        <= report ? r_pm : 10'd0;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_control_seen         = r_o_ctrl_seen;
    assign o_control_type         = r_o_ctrl_type;
    assign o_channel_mhz          = r_o_chan;
    assign o_total_count          = r_o_total;
    assign o_lost_count           = r_o_lost;
    assign o_duplicate_count      = r_o_dup;
    assign o_packets_per_interval = r_o_pps;
    assign o_average_rssi_dbm     = r_o_avg;
    assign o_loss_per_mille       = r_o_pm;

    // A division is only started once the previous one has finished.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !div_busy)
        else $error("divider started while busy");

    // A new result never overwrites one that is still held by a stall.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || !i_out_stall))
        else $error("result register overwritten");

    // The loss ratio cannot exceed one thousand per mille.
    a_pm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_o_pm <= PER_MILLE))
        else $error("loss per mille out of range");

endmodule

>>> hdl/rx_packet_loss_monitor_top.sv
// Channel   Direction  Handshake                      Payload
// config    in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata
// event     in         i_in_valid / o_in_stall        i_op, i_crc_good, i_rssi_sample,
//                                                     i_packet_type, i_sequence_number
// result    out        o_out_valid / i_out_stall      o_control_seen ... o_loss_per_mille
//
// A packet, clear, unused op or non-reporting tick goes from accept through the
// prep and commit states into the result register. A reporting tick also passes twice
// through the one shared radix-2 divider: the mean RSSI, then the loss ratio.
// Reset is synchronous and active low; it clears the statistics and resets the config.
// The result register lets the next event beat be accepted while a result
// beat is still stalled; the block waits only before writing a new result.
module rx_packet_loss_monitor_top
    import rplm_pkg::*;
#(
    parameter int HOP_COUNT = HOP_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Event channel.
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_op,
    input  logic               i_crc_good,
    input  logic [6:0]         i_rssi_sample,
    input  logic [7:0]         i_packet_type,
    input  logic [31:0]        i_sequence_number,
    // Result channel.
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_control_seen,
    output logic [7:0]         o_control_type,
    output logic [11:0]        o_channel_mhz,
    output logic [31:0]        o_total_count,
    output logic [31:0]        o_lost_count,
    output logic [31:0]        o_duplicate_count,
    output logic [31:0]        o_packets_per_interval,
    output logic signed [7:0]  o_average_rssi_dbm,
    output logic [9:0]         o_loss_per_mille
);

    // Configuration registers. Registers sit at byte addresses 0 and 4, so
    // address bit 2 picks the register.
    logic       r_counting_en;
    logic [7:0] r_ctrl_mask;
    logic       cfg_write;
    logic       reg_sel;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counting_en <= 1'b0;
            r_ctrl_mask   <= MASK_RESET;
        end else if (cfg_write) begin
            case (reg_sel)
                REG_COUNTING: r_counting_en <= pwdata[0];
                REG_MASK:     r_ctrl_mask   <= pwdata[7:0];
                default:      r_ctrl_mask   <= r_ctrl_mask;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_COUNTING: prdata = {31'd0, r_counting_en};
            REG_MASK:     prdata = {24'd0, r_ctrl_mask};
            default:      prdata = 32'd0;
        endcase
    end

    // The controller sequences each event; the datapath holds the statistics,
    // the shared divider and the result register.
    t_cmd cmd;
    t_sts sts;

    rplm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    rplm_dp #(
        .HOP_COUNT (HOP_COUNT)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .o_sts                  (sts),
        .i_counting_en          (r_counting_en),
        .i_ctrl_mask            (r_ctrl_mask),
        .i_op                   (i_op),
        .i_crc_good             (i_crc_good),
        .i_rssi_sample          (i_rssi_sample),
        .i_packet_type          (i_packet_type),
        .i_sequence_number      (i_sequence_number),
        .i_out_stall            (i_out_stall),
        .o_out_valid            (o_out_valid),
        .o_control_seen         (o_control_seen),
        .o_control_type         (o_control_type),
        .o_channel_mhz          (o_channel_mhz),
        .o_total_count          (o_total_count),
        .o_lost_count           (o_lost_count),
        .o_duplicate_count      (o_duplicate_count),
        .o_packets_per_interval (o_packets_per_interval),
        .o_average_rssi_dbm     (o_average_rssi_dbm),
        .o_loss_per_mille       (o_loss_per_mille)
    );

endmodule

>>> tb/rx_packet_loss_monitor_top_test.sv
module rx_packet_loss_monitor_top_test;
    import rplm_pkg::*;

    // The op field has one code that the block does not use; it must leave
    // every statistic as it is and still return one result beat.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Receive frequency offsets of the hop sequence, in MHz above the band base.
    localparam logic [11:0] HOP_OFFSET_MHZ [8] = '{
        12'd2, 12'd14, 12'd36, 12'd56, 12'd66, 12'd78, 12'd0, 12'd22
    };

    localparam int MAX_IDLE = 18;

    // One event beat as the sender presents it.
    typedef struct packed {
        logic [1:0]  op;
        logic        crc;
        logic [6:0]  rssi;
        logic [7:0]  ptype;
        logic [31:0] seq;
    } t_link_event;

    // One result beat, field by field as it leaves the block.
    typedef struct packed {
        logic        ctl_seen;
        logic [7:0]  ctl_type;
        logic [11:0] mhz;
        logic [31:0] total;
        logic [31:0] lost;
        logic [31:0] dup;
        logic [31:0] per_interval;
        logic [7:0]  avg_dbm;
        logic [9:0]  per_mille;
    } t_link_report;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  in_op;
    logic        in_crc_good;
    logic [6:0]  in_rssi;
    logic [7:0]  in_ptype;
    logic [31:0] in_seq;
    logic        out_valid;
    logic        out_stall;
    logic        out_control_seen;
    logic [7:0]  out_control_type;
    logic [11:0] out_channel_mhz;
    logic [31:0] out_total;
    logic [31:0] out_lost;
    logic [31:0] out_dup;
    logic [31:0] out_per_interval;
    logic signed [7:0] out_avg_dbm;
    logic [9:0]  out_per_mille;

    // Local copy of the monitor: its configuration and its statistics.
    logic        count_en_cfg;
    logic [7:0]  ctl_mask_cfg;
    logic [31:0] total_pkts;
    logic [31:0] lost_pkts;
    logic [31:0] dup_pkts;
    logic [31:0] last_seq;
    logic        seq_known;
    logic [31:0] rssi_sum;
    logic [31:0] rssi_cnt;
    logic [31:0] total_at_tick;
    int          hop_idx;

    // Results that the monitor owes us, oldest first.
    t_link_report expected_reports[$];

    int          mismatches = 0;
    bit          reset_done = 0;
    // Random idling of each side is switched off for stretches of the run.
    bit          gap_idle_on = 1;
    bit          stall_idle_on = 1;
    // Sequence number of the last generated packet, so that random traffic
    // mostly forms plausible sequences.
    logic [31:0] seq_cursor;

    rx_packet_loss_monitor_top dut (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .psel                   (psel),
        .penable                (penable),
        .pwrite                 (pwrite),
        .paddr                  (paddr),
        .pwdata                 (pwdata),
        .prdata                 (prdata),
        .pready                 (pready),
        .i_in_valid             (in_valid),
        .o_in_stall             (in_stall),
        .i_op                   (in_op),
        .i_crc_good             (in_crc_good),
        .i_rssi_sample          (in_rssi),
        .i_packet_type          (in_ptype),
        .i_sequence_number      (in_seq),
        .o_out_valid            (out_valid),
        .i_out_stall            (out_stall),
        .o_control_seen         (out_control_seen),
        .o_control_type         (out_control_type),
        .o_channel_mhz          (out_channel_mhz),
        .o_total_count          (out_total),
        .o_lost_count           (out_lost),
        .o_duplicate_count      (out_dup),
        .o_packets_per_interval (out_per_interval),
        .o_average_rssi_dbm     (out_avg_dbm),
        .o_loss_per_mille       (out_per_mille)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Puts the local copy of the monitor in its state after reset.
    task automatic reset_link_model();
        count_en_cfg  = 1'b0;
        ctl_mask_cfg  = MASK_RESET;
        total_pkts    = '0;
        lost_pkts     = '0;
        dup_pkts      = '0;
        last_seq      = '0;
        seq_known     = 1'b0;
        rssi_sum      = '0;
        rssi_cnt      = '0;
        total_at_tick = '0;
        hop_idx       = 0;
    endtask

    // Applies one accepted event to the local statistics and returns the
    // result beat that the block must produce for it.
    function automatic t_link_report compute_link_report(t_link_event ev);
        t_link_report r;
        logic [31:0]  mean;
        logic [63:0]  denom;
        r = '0;
        case (ev.op)
            OP_PACKET: begin
                // A packet that failed its CRC leaves everything alone.
                if (ev.crc) begin
                    rssi_sum = rssi_sum + 32'(ev.rssi);
                    rssi_cnt = rssi_cnt + 32'd1;
                    if ((ev.ptype & ctl_mask_cfg) != 8'd0) begin
                        r.ctl_seen = 1'b1;
                        r.ctl_type = ev.ptype;
                    end else if (count_en_cfg) begin
                        total_pkts = total_pkts + 32'd1;
                        if (!seq_known) begin
                            seq_known = 1'b1;
                            last_seq  = ev.seq;
                        end else if (ev.seq == last_seq) begin
                            dup_pkts = dup_pkts + 32'd1;
                        end else begin
                            // A backwards step wraps modulo 2^32.
                            lost_pkts = lost_pkts + (ev.seq - last_seq - 32'd1);
                            last_seq  = ev.seq;
                        end
                    end
                    hop_idx = (hop_idx + 1) % HOP_COUNT_DEF;
                end
            end
            OP_TICK: begin
                // With counting off a tick reports nothing and keeps the RSSI.
                if (count_en_cfg) begin
                    denom = {32'd0, total_pkts} + {32'd0, lost_pkts};
                    r.per_interval = total_pkts - total_at_tick;
                    if (rssi_cnt != 32'd0) begin
                        mean = rssi_sum / rssi_cnt;
                        if (mean > 32'(RSSI_MAX)) begin
                            mean = 32'(RSSI_MAX);
                        end
                        r.avg_dbm = 8'(32'd0 - mean);
                    end
                    if (denom != 64'd0) begin
                        r.per_mille = 10'(({32'd0, lost_pkts} * 64'(PER_MILLE)) / denom);
                    end
                    total_at_tick = total_pkts;
                    rssi_sum      = '0;
                    rssi_cnt      = '0;
                end
            end
            OP_CLEAR: begin
                total_pkts    = '0;
                lost_pkts     = '0;
                dup_pkts      = '0;
                total_at_tick = '0;
                seq_known     = 1'b0;
            end
            default: begin
            end
        endcase
        r.mhz   = BASE_MHZ + HOP_OFFSET_MHZ[hop_idx % 8];
        r.total = total_pkts;
        r.lost  = lost_pkts;
        r.dup   = dup_pkts;
        return r;
    endfunction

    function automatic void check_field(string label, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
            mismatches++;
        end
    endfunction

    function automatic t_link_event make_event(logic [1:0] op, logic crc, logic [6:0] rssi,
                                               logic [7:0] ptype, logic [31:0] seq);
        t_link_event ev;
        ev.op    = op;
        ev.crc   = crc;
        ev.rssi  = rssi;
        ev.ptype = ptype;
        ev.seq   = seq;
        return ev;
    endfunction

    // Random traffic: mostly good data packets whose sequence numbers run on
    // in order, with duplicates, small gaps, backwards steps and wild jumps,
    // some control packets, bad CRCs, ticks, the occasional clear and an unused op.
    function automatic t_link_event make_random_event();
        t_link_event ev;
        int          pick;
        ev.op    = OP_PACKET;
        ev.crc   = ($urandom_range(0, 9) != 0);
        ev.rssi  = 7'($urandom);
        ev.seq   = $urandom;
        ev.ptype = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick >= 98) begin
            ev.op = OP_UNUSED;
        end else if (pick >= 95) begin
            ev.op = OP_CLEAR;
        end else if (pick >= 83) begin
            ev.op = OP_TICK;
        end else begin
            if ($urandom_range(0, 4) != 0) begin
                ev.ptype = ev.ptype & ~ctl_mask_cfg;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                ev.seq = seq_cursor + 32'd1;
            end else if (pick < 80) begin
                ev.seq = seq_cursor;
            end else if (pick < 90) begin
                ev.seq = seq_cursor + 32'($urandom_range(2, 12));
            end else if (pick < 95) begin
                ev.seq = seq_cursor - 32'($urandom_range(1, 8));
            end
            seq_cursor = ev.seq;
        end
        return ev;
    endfunction

    // Presents one event beat and returns right after the edge that accepted
    // it. The expectation is queued at the falling edge just before that edge,
    // once the stall seen there shows the beat will be taken.
    task automatic send_event(input t_link_event ev);
        int gap;
        bit taken;
        gap = gap_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_op       <= ev.op;
        in_crc_good <= ev.crc;
        in_rssi     <= ev.rssi;
        in_ptype    <= ev.ptype;
        in_seq      <= ev.seq;
        taken = 0;
        while (!taken) begin
            @(negedge clk);
            if (!in_stall) begin
                expected_reports.push_back(compute_link_report(ev));
                taken = 1;
            end
            @(posedge clk);
        end
    endtask

    // Stops sending and waits until every owed result beat has come back,
    // then lets the clock run on so that the block is fully at rest.
    task automatic wait_link_idle();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Reads one register over the configuration port and compares it. The
    // data is sampled at the falling edge inside the access cycle.
    task automatic read_register_check(input logic reg_idx, input logic [31:0] want);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        check_field(reg_idx == REG_COUNTING ? "counting_enabled readback"
                                            : "control_type_mask readback", want, prdata);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes one register (setup cycle, then access cycle) and reads it back.
    // Callers make sure the block is idle first.
    task automatic write_config(input logic reg_idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_COUNTING) begin
            count_en_cfg = value[0];
        end else begin
            ctl_mask_cfg = value[7:0];
        end
        read_register_check(reg_idx, reg_idx == REG_COUNTING ? {31'd0, count_en_cfg}
                                                             : {24'd0, ctl_mask_cfg});
    endtask

    // After reset, counting is off and the mask marks only the top type bit.
    // Packets then only move the hop and the RSSI, and a tick reports nothing.
    task automatic test_register_reset();
        read_register_check(REG_COUNTING, 32'd0);
        read_register_check(REG_MASK, {24'd0, MASK_RESET});
        send_event(make_event(OP_PACKET, 1'b1, 7'd40, 8'h00, 32'd7));
        send_event(make_event(OP_PACKET, 1'b1, 7'd50, 8'h80, 32'd8));
        send_event(make_event(OP_TICK, 1'b0, 7'd0, 8'h00, 32'd0));
        wait_link_idle();
    endtask

    // Short hand-picked sequence: bad CRC, the first data packet, the wrap
    // from all ones to zero, a duplicate, a gap, a backwards step, control
    // packets, ticks with and without samples, clear, the unused op code,
    // both mask extremes, and counting switched off and on again.
    task automatic test_directed_cases();
        write_config(REG_COUNTING, 32'd1);
        send_event(make_event(OP_PACKET, 1'b0, 7'd127, 8'h00, 32'h1234_5678));
        send_event(make_event(OP_PACKET, 1'b1, 7'd127, 8'h00, 32'hFFFF_FFFF));
        send_event(make_event(OP_PACKET, 1'b1, 7'd0, 8'h00, 32'h0000_0000));
        send_event(make_event(OP_PACKET, 1'b1, 7'd64, 8'h00, 32'h0000_0000));
        send_event(make_event(OP_PACKET, 1'b1, 7'd1, 8'h7F, 32'd5));
        send_event(make_event(OP_PACKET, 1'b1, 7'd90, 8'h00, 32'd3));
        send_event(make_event(OP_PACKET, 1'b1, 7'd10, 8'hFF, 32'd3));
        send_event(make_event(OP_TICK, 1'b1, 7'd127, 8'hFF, 32'hFFFF_FFFF));
        send_event(make_event(OP_TICK, 1'b0, 7'd0, 8'h00, 32'd0));
        send_event(make_event(OP_CLEAR, 1'b1, 7'd33, 8'h55, 32'hA5A5_A5A5));
        send_event(make_event(OP_TICK, 1'b0, 7'd0, 8'h00, 32'd0));
        send_event(make_event(OP_UNUSED, 1'b1, 7'd55, 8'hAA, 32'h5A5A_5A5A));
        send_event(make_event(OP_PACKET, 1'b1, 7'd20, 8'h00, 32'd100));
        wait_link_idle();
        write_config(REG_MASK, 32'd0);
        send_event(make_event(OP_PACKET, 1'b1, 7'd30, 8'hFF, 32'd101));
        wait_link_idle();
        write_config(REG_MASK, 32'd255);
        send_event(make_event(OP_PACKET, 1'b1, 7'd31, 8'h01, 32'd102));
        send_event(make_event(OP_PACKET, 1'b1, 7'd32, 8'h00, 32'd102));
        wait_link_idle();
        write_config(REG_COUNTING, 32'd0);
        send_event(make_event(OP_PACKET, 1'b1, 7'd70, 8'h00, 32'd200));
        send_event(make_event(OP_TICK, 1'b0, 7'd0, 8'h00, 32'd0));
        send_event(make_event(OP_CLEAR, 1'b0, 7'd0, 8'h00, 32'd0));
        wait_link_idle();
        write_config(REG_COUNTING, 32'd1);
        send_event(make_event(OP_TICK, 1'b0, 7'd0, 8'h00, 32'd0));
        wait_link_idle();
    endtask

    // Random traffic in several configuration phases, both extremes of the
    // mask among them. Idling of each side is redrawn every few beats so
    // that some stretches run back to back.
    task automatic test_random_traffic();
        logic        phase_en   [6];
        logic [31:0] phase_mask [6];
        phase_en   = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        phase_mask = '{32'd128, 32'd0, 32'd255, 32'($urandom_range(0, 255)),
                       32'($urandom_range(0, 255)), 32'd128};
        seq_cursor = $urandom;
        for (int p = 0; p < 6; p++) begin
            wait_link_idle();
            write_config(REG_COUNTING, {31'd0, phase_en[p]});
            write_config(REG_MASK, phase_mask[p]);
            for (int i = 0; i < 106; i++) begin
                if (i % 18 == 0) begin
                    gap_idle_on   = ($urandom_range(0, 3) != 0);
                    stall_idle_on = ($urandom_range(0, 3) != 0);
                end
                // Once mid-phase the sender holds off until the block has
                // returned everything it owes.
                if (p == 2 && i == 53) begin
                    wait_link_idle();
                end
                send_event(make_random_event());
            end
        end
        gap_idle_on   = 1;
        stall_idle_on = 1;
    endtask

    // Result side: before each beat the receiver may raise its stall at random,
    // then takes the next beat and compares it with the oldest expectation.
    // Outputs are sampled at the falling edge, where they are settled.
    initial begin
        t_link_report want;
        int           hold;
        bit           got;
        out_stall <= 1'b0;
        wait (reset_done);
        @(posedge clk);
        forever begin
            hold = stall_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            got = 0;
            while (!got) begin
                @(negedge clk);
                if (out_valid) begin
                    got = 1;
                    if (expected_reports.size() == 0) begin
                        $display("%0t: result beat with no expectation waiting", $time);
                        mismatches++;
                    end else begin
                        want = expected_reports.pop_front();
                        check_field("control_seen", 32'(want.ctl_seen), 32'(out_control_seen));
                        check_field("control_type", 32'(want.ctl_type), 32'(out_control_type));
                        check_field("channel_mhz", 32'(want.mhz), 32'(out_channel_mhz));
                        check_field("total_count", want.total, out_total);
                        check_field("lost_count", want.lost, out_lost);
                        check_field("duplicate_count", want.dup, out_dup);
                        check_field("packets_per_interval", want.per_interval,
                                    out_per_interval);
                        check_field("average_rssi_dbm", {24'd0, want.avg_dbm},
                                    {24'd0, out_avg_dbm});
                        check_field("loss_per_mille", 32'(want.per_mille),
                                    32'(out_per_mille));
                    end
                end
                @(posedge clk);
            end
        end
    end

    // Main sequence: reset once, run the tests in turn, then drain and give
    // the block time to show any stray result beat before the verdict.
    initial begin
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_valid    <= 1'b0;
        in_op       <= OP_PACKET;
        in_crc_good <= 1'b0;
        in_rssi     <= '0;
        in_ptype    <= '0;
        in_seq      <= '0;
        reset_link_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        reset_done = 1;
        @(posedge clk);
        test_register_reset();
        test_directed_cases();
        test_random_traffic();
        wait_link_idle();
        // This wait outlasts a reporting tick, so it covers a late beat.
        repeat (120) @(posedge clk);
        if (mismatches == 0) begin
            $display("rx_packet_loss_monitor_top regression: pass");
        end else begin
            $display("rx_packet_loss_monitor_top regression: fail");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run, where every beat meets
    // the longest sender gap, the longest receiver stall and a reporting tick.
    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d result beats outstanding", $time,
                 expected_reports.size());
        $display("rx_packet_loss_monitor_top regression: fail");
        $finish;
    end

endmodule
